FILE: design/lpfp_pkg.sv
// ----------------------------------------------------------------------------
// lpfp_pkg
// Shared types, byte codes and the bytewise crc-16 update for the deframer.
// ----------------------------------------------------------------------------
package lpfp_pkg;

  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_LEN  = 3'd1,
    PH_PAY  = 3'd2,
    PH_CRCH = 3'd3,
    PH_CRCL = 3'd4,
    PH_STOP = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_GOOD    = 2'd1,
    EV_BAD_LEN = 2'd2,
    EV_BAD_CRC = 2'd3
  } event_e;

  typedef enum logic {
    ACT_RECV = 1'b0,
    ACT_READ = 1'b1
  } action_e;

  localparam logic [7:0]  START_SHORT = 8'd2;
  localparam logic [7:0]  START_MID   = 8'd3;
  localparam logic [7:0]  START_LONG  = 8'd4;
  localparam logic [7:0]  STOP_BYTE   = 8'd3;
  localparam logic [2:0]  KIND_MID    = 3'd3;
  localparam logic [2:0]  KIND_LONG   = 3'd4;
  localparam logic [23:0] MIN_MID     = 24'h0000FF;
  localparam logic [23:0] MIN_LONG    = 24'h00FFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;

  // crc-16 xmodem, one byte, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: design/length_prefixed_frame_parser.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser
// Byte-wise deframer for start / length / payload / crc-16 / stop frames,
// with a payload buffer that can be read back one byte per request.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | input     | in_valid_i, in_stall_o | action_i, data_byte_i,
//          |           |                        | read_index_i
//  out     | output    | out_valid_o,out_stall_i| event_res_o, frame_length_o,
//          |           |                        | read_data_o, in_frame_o
//
//  one request per cycle while in_stall_o is low; its result is in the output register in the cycle after accept
//  the parser state, crc and buffer write or read all complete at accept
//  in_stall_o is high only while a held result is stalled on the out side
//  reset returns to waiting for a start byte with good length zero
//  buffer contents are not cleared by reset
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser #(
  parameter int unsigned MAX_PAYLOAD = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       action_i,
  input  logic [7:0] data_byte_i,
  input  logic [8:0] read_index_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] event_res_o,
  output logic [9:0] frame_length_o,
  output logic [7:0] read_data_o,
  output logic       in_frame_o
);

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned IW = (CW > 9) ? CW : 9;

  lpfp_pkg::phase_e phase_q, phase_d;
  logic [2:0]       kind_q, kind_d;
  logic [1:0]       need_q, need_d;
  logic [1:0]       seen_q, seen_d;
  logic [23:0]      len_q, len_d;
  logic [CW-1:0]    count_q, count_d;
  logic [15:0]      rx_crc_q, rx_crc_d;
  logic [15:0]      run_crc_q, run_crc_d;
  logic [CW-1:0]    good_len_q, good_len_d;

  logic             out_valid_q;
  logic [1:0]       event_q, event_d;
  logic [9:0]       flen_q, flen_d;
  logic             in_frame_q;
  logic             rd_ok_q, rd_ok_d;
  logic [7:0]       rdata_q;

  logic [7:0]       mem_q [MAX_PAYLOAD];

  logic             accept;
  logic             recv;
  logic [23:0]      len_shift;
  logic             len_done;
  logic             len_bad;
  logic [CW-1:0]    count_inc;
  logic             crc_match;
  logic [IW-1:0]    idx_w;
  logic [AW-1:0]    rd_addr;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign recv       = (action_i == lpfp_pkg::ACT_RECV);

  assign len_shift = {len_q[15:0], data_byte_i};
  assign seen_d    = seen_q + 2'd1;
  assign len_done  = (seen_d >= need_q);
  assign len_bad   = (len_shift == 24'd0) || (len_shift > 24'(MAX_PAYLOAD)) ||
                     ((kind_q == lpfp_pkg::KIND_MID) && (len_shift < lpfp_pkg::MIN_MID)) ||
                     ((kind_q == lpfp_pkg::KIND_LONG) && (len_shift < lpfp_pkg::MIN_LONG));
  assign count_inc = count_q + CW'(1);
  assign crc_match = (data_byte_i == lpfp_pkg::STOP_BYTE) && (rx_crc_q == run_crc_q);

  assign idx_w   = IW'(read_index_i);
  assign rd_addr = idx_w[AW-1:0];

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (recv) begin
      unique case (phase_q)
        lpfp_pkg::PH_WAIT: begin
          if (data_byte_i >= lpfp_pkg::START_SHORT && data_byte_i <= lpfp_pkg::START_LONG) begin
            phase_d = lpfp_pkg::PH_LEN;
          end
        end
        lpfp_pkg::PH_LEN: begin
          if (len_done) begin
            phase_d = len_bad ? lpfp_pkg::PH_WAIT : lpfp_pkg::PH_PAY;
          end
        end
        lpfp_pkg::PH_PAY: begin
          if (24'(count_inc) >= len_q) begin
            phase_d = lpfp_pkg::PH_CRCH;
          end
        end
        lpfp_pkg::PH_CRCH: phase_d = lpfp_pkg::PH_CRCL;
        lpfp_pkg::PH_CRCL: phase_d = lpfp_pkg::PH_STOP;
        default:           phase_d = lpfp_pkg::PH_WAIT;
      endcase
    end
  end

  // frame fields and result
  always_comb begin
    kind_d     = kind_q;
    need_d     = need_q;
    len_d      = len_q;
    count_d    = count_q;
    rx_crc_d   = rx_crc_q;
    run_crc_d  = run_crc_q;
    good_len_d = good_len_q;
    event_d    = lpfp_pkg::EV_NONE;
    flen_d     = 10'd0;
    rd_ok_d    = 1'b0;
    if (recv) begin
      unique case (phase_q)
        lpfp_pkg::PH_WAIT: begin
          if (data_byte_i >= lpfp_pkg::START_SHORT && data_byte_i <= lpfp_pkg::START_LONG) begin
            kind_d = data_byte_i[2:0];
            need_d = data_byte_i[1:0] - 2'd1;
          end
        end
        lpfp_pkg::PH_LEN: begin
          len_d = len_shift;
          if (len_done && len_bad) begin
            event_d = lpfp_pkg::EV_BAD_LEN;
          end
        end
        lpfp_pkg::PH_PAY: begin
          count_d   = count_inc;
          run_crc_d = lpfp_pkg::crc_byte(run_crc_q, data_byte_i);
        end
        lpfp_pkg::PH_CRCH: rx_crc_d = {data_byte_i, 8'h00};
        lpfp_pkg::PH_CRCL: rx_crc_d = {rx_crc_q[15:8], data_byte_i};
        default: begin
          if (crc_match) begin
            event_d    = lpfp_pkg::EV_GOOD;
            good_len_d = CW'(len_q);
            flen_d     = 10'(len_q);
          end else begin
            event_d = lpfp_pkg::EV_BAD_CRC;
          end
        end
      endcase
      // leaving a frame clears its fields
      if (phase_d == lpfp_pkg::PH_WAIT) begin
        kind_d    = 3'd0;
        need_d    = 2'd0;
        len_d     = 24'd0;
        count_d   = '0;
        rx_crc_d  = 16'd0;
        run_crc_d = 16'd0;
      end
    end else begin
      rd_ok_d = (idx_w < IW'(good_len_q)) && (idx_w < IW'(MAX_PAYLOAD));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= lpfp_pkg::PH_WAIT;
      kind_q      <= 3'd0;
      need_q      <= 2'd0;
      seen_q      <= 2'd0;
      len_q       <= 24'd0;
      count_q     <= '0;
      rx_crc_q    <= 16'd0;
      run_crc_q   <= 16'd0;
      good_len_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q    <= phase_d;
        kind_q     <= kind_d;
        need_q     <= need_d;
        len_q      <= len_d;
        count_q    <= count_d;
        rx_crc_q   <= rx_crc_d;
        run_crc_q  <= run_crc_d;
        good_len_q <= good_len_d;
        if (recv) begin
          if ((phase_q == lpfp_pkg::PH_LEN) && !(phase_d == lpfp_pkg::PH_WAIT)) begin
            seen_q <= seen_d;
          end else begin
            seen_q <= 2'd0;
          end
        end
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      event_q    <= event_d;
      flen_q     <= flen_d;
      in_frame_q <= (phase_d != lpfp_pkg::PH_WAIT);
      rd_ok_q    <= rd_ok_d;
    end
  end

  // payload buffer
  always_ff @(posedge clk_i) begin
    if (accept && recv && (phase_q == lpfp_pkg::PH_PAY)) begin
      mem_q[count_q[AW-1:0]] <= data_byte_i;
    end
    if (accept && !recv) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_res_o    = event_q;
  assign frame_length_o = flen_q;
  assign read_data_o    = rd_ok_q ? rdata_q : 8'd0;
  assign in_frame_o     = in_frame_q;

  a_good_ends_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o == lpfp_pkg::EV_GOOD) |-> !in_frame_o)
    else $error("good frame reported while still in frame");

  a_len_only_good : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o != lpfp_pkg::EV_GOOD) |-> (frame_length_o == 10'd0))
    else $error("frame length without good frame");

  a_read_no_event : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (read_data_o != 8'd0) |-> (event_res_o == lpfp_pkg::EV_NONE))
    else $error("read data alongside a frame event");

  a_good_len_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(good_len_q) <= MAX_PAYLOAD)
    else $error("good length above buffer size");

  a_count_in_buffer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == lpfp_pkg::PH_PAY) |-> (32'(count_q) < MAX_PAYLOAD))
    else $error("payload count beyond buffer");

endmodule

FILE: verif/length_prefixed_frame_parser_tb.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser_tb
// Drives stream bytes and buffer reads into the deframer, predicts every
// result with a bit-level model of the frame parser and its payload buffer,
// and compares each accepted result against the oldest prediction. The
// sender idles and the receiver stalls in random bursts; the tail of the run goes flat out.
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser_tb;

  localparam int unsigned MAX_PAYLOAD = 512;
  localparam int unsigned NUM_ITEMS   = 1300;
  localparam int unsigned TAIL_ITEMS  = 1100;
  localparam int unsigned WDOG_LIMIT  = 2000;

  typedef enum int {
    FRM_OK,
    FRM_BAD_CRC,
    FRM_BAD_STOP,
    FRM_CUT
  } frame_fault_e;

  typedef struct {
    lpfp_pkg::event_e ev;
    logic [9:0]       flen;
    logic [7:0]       rd;
    logic             inf;
  } deframe_result_t;

  class deframer_model;
    lpfp_pkg::phase_e phase;
    logic [2:0]       start_kind;
    logic [1:0]       len_need;
    logic [1:0]       len_seen;
    logic [23:0]      len_acc;
    logic [9:0]       pay_cnt;
    logic [15:0]      rx_crc;
    logic [15:0]      run_crc;
    logic [7:0]       store [MAX_PAYLOAD];
    logic [9:0]       good_len;
    deframe_result_t  expected_results [$];
    int unsigned      errors;

    function new();
      clear_frame();
      good_len = '0;
      errors   = 0;
      foreach (store[i]) store[i] = '0;
    endfunction

    // bit-serial crc-16 xmodem, msb first
    static function logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c  = {c[14:0], 1'b0} ^ (fb ? lpfp_pkg::CRC_POLY : 16'h0000);
      end
      return c;
    endfunction

    function void clear_frame();
      phase      = lpfp_pkg::PH_WAIT;
      start_kind = '0;
      len_need   = '0;
      len_seen   = '0;
      len_acc    = '0;
      pay_cnt    = '0;
      rx_crc     = '0;
      run_crc    = '0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_request(lpfp_pkg::action_e act, logic [7:0] b, logic [8:0] idx);
      deframe_result_t r;
      r.ev   = lpfp_pkg::EV_NONE;
      r.flen = '0;
      r.rd   = '0;
      if (act == lpfp_pkg::ACT_RECV) begin
        case (phase)
          lpfp_pkg::PH_WAIT: begin
            if (b >= lpfp_pkg::START_SHORT && b <= lpfp_pkg::START_LONG) begin
              clear_frame();
              start_kind = b[2:0];
              len_need   = 2'(b - 8'd1);
              phase      = lpfp_pkg::PH_LEN;
            end
          end
          lpfp_pkg::PH_LEN: begin
            len_acc  = {len_acc[15:0], b};
            len_seen = len_seen + 2'd1;
            if (len_seen >= len_need) begin
              if (len_acc == 0 || len_acc > MAX_PAYLOAD ||
                  (start_kind == lpfp_pkg::KIND_MID && len_acc < lpfp_pkg::MIN_MID) ||
                  (start_kind == lpfp_pkg::KIND_LONG && len_acc < lpfp_pkg::MIN_LONG)) begin
                clear_frame();
                r.ev = lpfp_pkg::EV_BAD_LEN;
              end else begin
                pay_cnt = '0;
                run_crc = '0;
                phase   = lpfp_pkg::PH_PAY;
              end
            end
          end
          lpfp_pkg::PH_PAY: begin
            if (pay_cnt < MAX_PAYLOAD) store[pay_cnt[8:0]] = b;
            pay_cnt = pay_cnt + 10'd1;
            run_crc = crc16_update(run_crc, b);
            if (pay_cnt >= len_acc) phase = lpfp_pkg::PH_CRCH;
          end
          lpfp_pkg::PH_CRCH: begin
            rx_crc = {b, 8'h00};
            phase  = lpfp_pkg::PH_CRCL;
          end
          lpfp_pkg::PH_CRCL: begin
            rx_crc = {rx_crc[15:8], b};
            phase  = lpfp_pkg::PH_STOP;
          end
          default: begin
            if (b == lpfp_pkg::STOP_BYTE && rx_crc == run_crc) begin
              r.ev     = lpfp_pkg::EV_GOOD;
              good_len = len_acc[9:0];
              r.flen   = len_acc[9:0];
            end else begin
              r.ev = lpfp_pkg::EV_BAD_CRC;
            end
            clear_frame();
          end
        endcase
      end else if (idx < good_len) begin
        r.rd = store[idx];
      end
      r.inf = (phase != lpfp_pkg::PH_WAIT);
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [1:0] ev, logic [9:0] flen, logic [7:0] rd,
                               logic inf);
      deframe_result_t r;
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request pending, event_res %0d", $time, ev);
        errors++;
        return;
      end
      r = expected_results.pop_front();
      if (ev !== r.ev) begin
        $display("%0t: event_res expected %0d actual %0d", $time, r.ev, ev);
        errors++;
      end
      if (flen !== r.flen) begin
        $display("%0t: frame_length expected %0d actual %0d", $time, r.flen, flen);
        errors++;
      end
      if (rd !== r.rd) begin
        $display("%0t: read_data expected %0d actual %0d", $time, r.rd, rd);
        errors++;
      end
      if (inf !== r.inf) begin
        $display("%0t: in_frame expected %0d actual %0d", $time, r.inf, inf);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              in_stall_o;
  lpfp_pkg::action_e action_i     = lpfp_pkg::ACT_RECV;
  logic [7:0]        data_byte_i  = '0;
  logic [8:0]        read_index_i = '0;
  logic              out_valid_o;
  logic              out_stall_i  = 1'b0;
  logic [1:0]        event_res_o;
  logic [9:0]        frame_length_o;
  logic [7:0]        read_data_o;
  logic              in_frame_o;

  deframer_model sb = new();
  int unsigned   items_sent  = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   stall_left  = 0;
  bit            src_idle    = 1'b0;
  bit            sink_idle   = 1'b0;

  length_prefixed_frame_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .data_byte_i   (data_byte_i),
    .read_index_i  (read_index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_res_o   (event_res_o),
    .frame_length_o(frame_length_o),
    .read_data_o   (read_data_o),
    .in_frame_o    (in_frame_o)
  );

  always #2 clk_i = ~clk_i;

  // result check first, then note the new request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(event_res_o, frame_length_o, read_data_o, in_frame_o);
      end
      if (in_valid_i && !in_stall_o) begin
        sb.note_request(action_i, data_byte_i, read_index_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WDOG_LIMIT) begin
        $display("length_prefixed_frame_parser_tb: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // receiver stalls in random bursts while sink_idle is set
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (sink_idle && $urandom_range(0, 9) == 0) begin
      stall_left  <= $urandom_range(0, 8);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_req(lpfp_pkg::action_e act, logic [7:0] b, logic [8:0] idx);
    if (src_idle && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    data_byte_i  <= b;
    read_index_i <= idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_req(lpfp_pkg::ACT_RECV, b, 9'($urandom));
  endtask

  task automatic send_read(logic [8:0] idx);
    send_req(lpfp_pkg::ACT_READ, 8'($urandom), idx);
  endtask

  task automatic send_header(logic [7:0] start, logic [23:0] len);
    send_byte(start);
    for (int i = int'(start) - 2; i >= 0; i--) begin
      send_byte(len[i*8 +: 8]);
    end
  endtask

  task automatic send_frame(logic [7:0] start, logic [23:0] len, frame_fault_e fault);
    int          n;
    logic [15:0] c;
    logic [7:0]  b;
    send_header(start, len);
    n = (fault == FRM_CUT) ? $urandom_range(0, int'(len) - 1) : int'(len);
    c = '0;
    for (int k = 0; k < n; k++) begin
      b = 8'($urandom);
      c = deframer_model::crc16_update(c, b);
      send_byte(b);
    end
    if (fault == FRM_CUT) return;
    if (fault == FRM_BAD_CRC) c = c ^ (16'h0001 << $urandom_range(0, 15));
    send_byte(c[15:8]);
    send_byte(c[7:0]);
    do b = 8'($urandom); while (b == lpfp_pkg::STOP_BYTE);
    send_byte((fault == FRM_BAD_STOP) ? b : lpfp_pkg::STOP_BYTE);
  endtask

  // hold off the sender until every request has its result
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned  kind;
    int unsigned  big_left;
    int unsigned  sub;
    logic [23:0]  len;
    logic [7:0]   start;
    big_left = 2;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    send_read(9'd511);
    send_frame(lpfp_pkg::START_SHORT, 24'd1, FRM_OK);
    send_read(9'd0);
    send_header(lpfp_pkg::START_SHORT, 24'd0);
    send_header(lpfp_pkg::START_LONG, 24'h000100);
    send_header(lpfp_pkg::START_MID, 24'h000010);
    send_header(lpfp_pkg::START_MID, 24'h000201);
    send_frame(lpfp_pkg::START_SHORT, 24'd2, FRM_BAD_CRC);
    drain();

    // random
    while (items_sent < NUM_ITEMS) begin
      src_idle  = (items_sent < TAIL_ITEMS) && ($urandom_range(0, 3) != 0);
      sink_idle = (items_sent < TAIL_ITEMS) && ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        sub = $urandom_range(0, 19);
        if (sub == 0 && big_left != 0) begin
          len = (big_left == 2) ? 24'd512 : 24'(lpfp_pkg::MIN_MID);
          big_left--;
          send_frame(lpfp_pkg::START_MID, len, FRM_OK);
        end else if (sub == 1) begin
          len = $urandom_range(0, 1) ? 24'd255 : 24'($urandom_range(25, 120));
          send_frame(lpfp_pkg::START_SHORT, len, FRM_OK);
        end else begin
          send_frame(lpfp_pkg::START_SHORT, 24'($urandom_range(1, 24)), FRM_OK);
        end
      end else if (kind < 55) begin
        send_frame(lpfp_pkg::START_SHORT, 24'($urandom_range(1, 16)),
                   $urandom_range(0, 1) ? FRM_BAD_CRC : FRM_BAD_STOP);
      end else if (kind < 63) begin
        sub = $urandom_range(0, 3);
        case (sub)
          0: begin
            start = 8'($urandom_range(lpfp_pkg::START_SHORT, lpfp_pkg::START_LONG));
            send_header(start, 24'd0);
          end
          1: send_header(lpfp_pkg::START_MID, 24'($urandom_range(513, 65535)));
          2: send_header(lpfp_pkg::START_MID, 24'($urandom_range(1, 254)));
          default: send_header(lpfp_pkg::START_LONG, 24'($urandom));
        endcase
      end else if (kind < 70) begin
        send_frame(lpfp_pkg::START_SHORT, 24'($urandom_range(2, 20)), FRM_CUT);
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 4)) begin
          if (sb.good_len != 0 && $urandom_range(0, 9) < 7) begin
            send_read(9'($urandom_range(0, int'(sb.good_len) - 1)));
          end else begin
            send_read(9'($urandom));
          end
        end
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end
      if ($urandom_range(0, 49) == 0) drain();
    end

    src_idle  = 1'b0;
    sink_idle = 1'b0;
    drain();
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("length_prefixed_frame_parser_tb: clean");
    end else begin
      $display("length_prefixed_frame_parser_tb: errors");
    end
    $finish;
  end

endmodule

FILE: length_prefixed_frame_parser.f
design/lpfp_pkg.sv
design/length_prefixed_frame_parser.sv
verif/length_prefixed_frame_parser_tb.sv
